[rtl/drsm_pkg.sv]
// Shared types and constants of the depth row smoother.
`timescale 1ns / 1ps

package drsm_pkg;

  localparam int DEPTH_W    = 16;
  localparam int WEIGHT_W   = 9;
  localparam int LIMIT_W    = 16;
  localparam int ROWW_W     = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int QDEPTH     = 2;
  localparam int ROUND_HALF = 128;

  // register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_BLEND_WEIGHT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_LIMIT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH    = 2'd2;

  // request codes
  localparam logic REQ_PUSH = 1'b0;

  localparam logic [WEIGHT_W-1:0] BLEND_ONE        = 9'd256;
  localparam logic [WEIGHT_W-1:0] BLEND_WEIGHT_RST = 9'd128;
  localparam logic [LIMIT_W-1:0]  EDGE_LIMIT_RST   = 16'd20;
  localparam logic [ROWW_W-1:0]   ROW_WIDTH_RST    = 11'd640;

  typedef struct packed {
    logic               push;
    logic [DEPTH_W-1:0] pixel;
  } cmd_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] blend_weight;
    logic [LIMIT_W-1:0]  edge_limit;
    logic [ROWW_W-1:0]   row_width;
  } cfg_t;

endpackage

[rtl/drsm_if.sv]
// Channel interfaces of the depth row smoother: requests, results, configuration.
`timescale 1ns / 1ps

interface drsm_req_if import drsm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [DEPTH_W-1:0] depth_in;

  modport source (output valid, output req_type, output depth_in, input ready);
  modport sink   (input valid, input req_type, input depth_in, output ready);
endinterface

interface drsm_rsp_if import drsm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DEPTH_W-1:0] depth_out;
  logic               out_valid;
  logic               row_last;

  modport source (output valid, output depth_out, output out_valid, output row_last,
                  input ready);
  modport sink   (input valid, input depth_out, input out_valid, input row_last,
                  output ready);
endinterface

interface drsm_cfg_if import drsm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/depth_row_edge_preserving_smoother_core.sv]
// Top level of the depth row smoother: configuration registers, front and back ends.
`timescale 1ns / 1ps

// Edge-preserving row smoother for depth pixels in raster order, zero marking
// a hole. Each push (req_type 0) is blended left to right against the running
// state as it arrives and stored; when a row is complete it is swept right to
// left in place. Every request (push or drain) returns exactly one result: the
// next pixel of the previously completed row (out_valid 1, row_last on its
// final column) or, when no row is pending, out_valid 0 with zero fields.
// A completed row is visible from the request after the one that completed it.
// A request waiting in the queue is popped as the one before it executes when
// the execute stage is busy; from idle it is popped first and executes after.
// The push that ends a row is followed by the right-to-left sweep over the
// row's other entries, one entry per cycle through the single read and write
// port of the row store, after which the back end goes idle. The input queue
// keeps taking requests while the back end sweeps or a result waits unread,
// until its two entries are full. The row store is two banks of MAX_ROW_PIXELS
// pixels with no clearing pass after reset. Configuration writes are taken
// every cycle and must only be made while no request is outstanding.

module depth_row_edge_preserving_smoother_core import drsm_pkg::*; #(
  parameter int MAX_ROW_PIXELS = 1024,
  parameter int PIXEL_BITS     = 16
) (
  input  logic        clk,
  input  logic        rst,
  drsm_req_if.sink    req,
  drsm_rsp_if.source  rsp,
  drsm_cfg_if.sink    cfg
);

  cfg_t cfg_regs;
  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;

  // configuration registers, always ready
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.blend_weight <= BLEND_WEIGHT_RST;
      cfg_regs.edge_limit   <= EDGE_LIMIT_RST;
      cfg_regs.row_width    <= ROW_WIDTH_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_BLEND_WEIGHT: cfg_regs.blend_weight <= cfg.data[WEIGHT_W-1:0];
        REG_EDGE_LIMIT:   cfg_regs.edge_limit   <= cfg.data[LIMIT_W-1:0];
        REG_ROW_WIDTH:    cfg_regs.row_width    <= cfg.data[ROWW_W-1:0];
        default:          cfg_regs <= cfg_regs;  // unmapped index: transfer ignored
      endcase
    end
  end

  // front: request intake and two-entry queue
  drsm_front u_front (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop)
  );

  // back: readout, blend, right-to-left sweep, result register
  drsm_back #(
    .MAX_ROW_PIXELS (MAX_ROW_PIXELS),
    .PIXEL_BITS     (PIXEL_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_regs),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop),
    .rsp     (rsp)
  );

endmodule

[rtl/drsm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module drsm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/drsm_front.sv]
// Front end: takes requests, classifies push/drain, buffers them in a short queue.
`timescale 1ns / 1ps

module drsm_front import drsm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  drsm_req_if.sink    req,
  output logic        q_valid,
  output cmd_t        q_cmd,
  input  logic        q_pop
);

  localparam int PW = $clog2(QDEPTH);

  cmd_t          slot [QDEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;
  logic          take;

  assign req.ready = (count != (PW+1)'(QDEPTH));
  assign take      = req.valid && req.ready;
  assign q_valid   = (count != '0);
  assign q_cmd     = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (take) begin
      slot[wr_ptr] <= '{push: (req.req_type == REQ_PUSH), pixel: req.depth_in};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (take) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      case ({take, q_pop})
        2'b10:   count <= count + (PW+1)'(1);
        2'b01:   count <= count - (PW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/drsm_back.sv]
// Back end: readout, left-to-right blend on push, right-to-left sweep per row.
`timescale 1ns / 1ps

module drsm_back import drsm_pkg::*; #(
  parameter int MAX_ROW_PIXELS = 1024,
  parameter int PIXEL_BITS     = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        q_valid,
  input  cmd_t        q_cmd,
  output logic        q_pop,
  drsm_rsp_if.source  rsp
);

  localparam int CW = $clog2(MAX_ROW_PIXELS);
  localparam int WW = CW + 1;
  localparam int AW = $clog2(2 * MAX_ROW_PIXELS);
  localparam int PB = PIXEL_BITS;
  localparam int MW = PB + 11;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_SWEEP} state_t;

  function automatic logic [AW-1:0] row_addr(input logic b, input logic [CW-1:0] c);
    row_addr = b ? (AW'(MAX_ROW_PIXELS) + AW'(c)) : AW'(c);
  endfunction

  // registers
  state_t              state, state_next;
  cmd_t                cur, cur_next;
  logic [PB-1:0]       blend_state, blend_state_next;
  logic [PB-1:0]       prev_raw, prev_raw_next;
  logic [CW-1:0]       wr_col, wr_col_next;
  logic [CW-1:0]       rd_col, rd_col_next;
  logic                bank, bank_next;
  logic                row_ready, row_ready_next;
  logic [CW-1:0]       sw_idx, sw_idx_next;
  logic [PB-1:0]       sw_st, sw_st_next;
  logic [PB-1:0]       sw_prev, sw_prev_next;
  logic                res_v, res_v_next;
  logic [DEPTH_W-1:0]  res_depth, res_depth_next;
  logic                res_out_valid, res_out_valid_next;
  logic                res_row_last, res_row_last_next;

  // ram port
  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [PB-1:0]       ram_wdata, rdata;

  // datapath
  logic [WW-1:0]       eff_w;
  logic [31:0]         rw_wide;
  logic [WEIGHT_W-1:0] w_sat;
  logic [PB-1:0]       x_in, y, b_x, b_st, b_prev, b_diff, b_mix;
  logic                b_ok, fire, rd_last, wr_last, is_first, go_on;
  logic signed [PB:0]  b_delta;
  logic signed [MW-1:0] b_prod, b_acc;

  drsm_ram #(.WIDTH(PB), .DEPTH(2 * MAX_ROW_PIXELS)) u_row_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  // row width clamped to [1, MAX_ROW_PIXELS]
  assign rw_wide = 32'(cfg.row_width);
  always_comb begin
    if (rw_wide == 32'd0) begin
      eff_w = WW'(1);
    end else if (rw_wide > 32'(MAX_ROW_PIXELS)) begin
      eff_w = WW'(MAX_ROW_PIXELS);
    end else begin
      eff_w = WW'(rw_wide);
    end
  end

  assign w_sat = (cfg.blend_weight > BLEND_ONE) ? BLEND_ONE : cfg.blend_weight;
  assign x_in  = PB'(cur.pixel);

  // shared blend unit: st*256 + (x - st)*w + half, then >> 8
  always_comb begin
    if (state == S_SWEEP) begin
      b_x    = rdata;
      b_st   = sw_st;
      b_prev = sw_prev;
    end else begin
      b_x    = x_in;
      b_st   = blend_state;
      b_prev = prev_raw;
    end
  end

  assign b_diff  = (b_x > b_prev) ? (b_x - b_prev) : (b_prev - b_x);
  assign b_ok    = (b_prev != '0) && (32'(b_diff) < 32'(cfg.edge_limit));
  assign b_delta = $signed({1'b0, b_x}) - $signed({1'b0, b_st});
  assign b_prod  = b_delta * $signed({1'b0, w_sat});
  assign b_acc   = (MW'($signed({1'b0, b_st})) <<< 8) + b_prod + MW'(ROUND_HALF);
  assign b_mix   = b_acc[PB+7:8];

  assign is_first = (wr_col == '0);
  always_comb begin
    if (is_first) begin
      y = x_in;
    end else if (x_in != '0) begin
      y = b_ok ? b_mix : x_in;
    end else begin
      y = '0;
    end
  end

  assign rd_last = (WW'(rd_col) + WW'(1)) >= eff_w;
  assign wr_last = (WW'(wr_col) + WW'(1)) >= eff_w;
  assign fire    = (state == S_EXEC) && (!res_v || rsp.ready);

  always_comb begin
    state_next         = state;
    cur_next           = cur;
    blend_state_next   = blend_state;
    prev_raw_next      = prev_raw;
    wr_col_next        = wr_col;
    rd_col_next        = rd_col;
    bank_next          = bank;
    row_ready_next     = row_ready;
    sw_idx_next        = sw_idx;
    sw_st_next         = sw_st;
    sw_prev_next       = sw_prev;
    res_v_next         = res_v && !rsp.ready;
    res_depth_next     = res_depth;
    res_out_valid_next = res_out_valid;
    res_row_last_next  = res_row_last;
    q_pop              = 1'b0;
    ram_we             = 1'b0;
    ram_waddr          = row_addr(bank, wr_col);
    ram_wdata          = y;
    ram_re             = 1'b0;
    ram_raddr          = row_addr(!bank, rd_col);
    go_on              = 1'b0;

    case (state)
      S_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          cur_next   = q_cmd;
          ram_re     = 1'b1;
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        if (fire) begin
          res_v_next         = 1'b1;
          res_out_valid_next = row_ready;
          res_depth_next     = row_ready ? DEPTH_W'(rdata) : '0;
          res_row_last_next  = row_ready && rd_last;
          if (row_ready) begin
            if (rd_last) begin
              rd_col_next    = '0;
              row_ready_next = 1'b0;
            end else begin
              rd_col_next = rd_col + CW'(1);
            end
          end
          go_on = 1'b1;
          if (cur.push) begin
            ram_we        = 1'b1;
            prev_raw_next = x_in;
            if (is_first || (x_in != '0)) begin
              blend_state_next = y;
            end
            if (wr_last) begin
              bank_next      = !bank;
              wr_col_next    = '0;
              rd_col_next    = '0;
              row_ready_next = 1'b1;
              go_on          = 1'b0;
              if (wr_col != '0) begin
                sw_idx_next  = wr_col - CW'(1);
                sw_st_next   = y;
                sw_prev_next = y;
                ram_re       = 1'b1;
                ram_raddr    = row_addr(bank, wr_col - CW'(1));
                state_next   = S_SWEEP;
              end else begin
                state_next = S_IDLE;
              end
            end else begin
              wr_col_next = wr_col + CW'(1);
            end
          end
          if (go_on) begin
            if (q_valid) begin
              q_pop     = 1'b1;
              cur_next  = q_cmd;
              ram_re    = 1'b1;
              ram_raddr = row_addr(!bank_next, rd_col_next);
            end else begin
              state_next = S_IDLE;
            end
          end
        end
      end

      S_SWEEP: begin
        // rdata holds the entry at sw_idx of the row just finished (bank flipped)
        if (rdata != '0) begin
          if (b_ok) begin
            sw_st_next = b_mix;
            ram_we     = 1'b1;
            ram_waddr  = row_addr(!bank, sw_idx);
            ram_wdata  = b_mix;
          end else begin
            sw_st_next = rdata;
          end
        end
        sw_prev_next = rdata;
        if (sw_idx == '0) begin
          state_next = S_IDLE;
        end else begin
          sw_idx_next = sw_idx - CW'(1);
          ram_re      = 1'b1;
          ram_raddr   = row_addr(!bank, sw_idx - CW'(1));
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      blend_state <= '0;
      prev_raw    <= '0;
      wr_col      <= '0;
      rd_col      <= '0;
      bank        <= 1'b0;
      row_ready   <= 1'b0;
      res_v       <= 1'b0;
    end else begin
      state       <= state_next;
      blend_state <= blend_state_next;
      prev_raw    <= prev_raw_next;
      wr_col      <= wr_col_next;
      rd_col      <= rd_col_next;
      bank        <= bank_next;
      row_ready   <= row_ready_next;
      res_v       <= res_v_next;
    end
    cur           <= cur_next;
    sw_idx        <= sw_idx_next;
    sw_st         <= sw_st_next;
    sw_prev       <= sw_prev_next;
    res_depth     <= res_depth_next;
    res_out_valid <= res_out_valid_next;
    res_row_last  <= res_row_last_next;
  end

  assign rsp.valid     = res_v;
  assign rsp.depth_out = res_depth;
  assign rsp.out_valid = res_out_valid;
  assign rsp.row_last  = res_row_last;

endmodule

[rtl/drsm_checker.sv]
// Port-level assertions for the depth row smoother, bound to its top level.
`timescale 1ns / 1ps

module drsm_checker import drsm_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input logic [DEPTH_W-1:0] rsp_depth_out,
  input logic               rsp_out_valid,
  input logic               rsp_row_last
);

  logic [3:0] owed;
  logic       req_xfer;
  logic       rsp_xfer;

  assign req_xfer = req_valid && req_ready;
  assign rsp_xfer = rsp_valid && rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      owed <= '0;
    end else begin
      case ({req_xfer, rsp_xfer})
        2'b10:   owed <= owed + 4'd1;
        2'b01:   owed <= owed - 4'd1;
        default: owed <= owed;
      endcase
    end
  end

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_depth_out) &&
      $stable(rsp_out_valid) && $stable(rsp_row_last))
    else $error("result changed while stalled");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_out_valid |-> rsp_depth_out == '0 && !rsp_row_last)
    else $error("empty result carries data");

  a_last_pixel: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_row_last |-> rsp_out_valid)
    else $error("row end flagged without a pixel");

  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> owed != '0)
    else $error("result offered with no request outstanding");

endmodule

bind depth_row_edge_preserving_smoother_core drsm_checker u_drsm_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_depth_out (rsp.depth_out),
  .rsp_out_valid (rsp.out_valid),
  .rsp_row_last  (rsp.row_last)
);

[verif/testbench.sv]
// Self-checking testbench for the depth row smoother: stimulus, predictor and result checks.
`timescale 1ns / 1ps

// Request transfers are driven from a queue that the stimulus process fills.
// A clocked monitor works out the expected result of every accepted request
// with its own copy of the smoother state: row store banks, running blend and
// readout position. It compares each result transfer with the oldest
// expectation. Past reset the stimulus process only acts on falling edges. The drivers
// and the monitor only act on rising edges, so nothing races within a step.
module testbench;
  import drsm_pkg::*;

  localparam int          ROW_PIXELS       = 64;  // row store banks of the core under test
  localparam int          SWEEP_SETTLE     = ROW_PIXELS + 32;
  localparam int          RECV_HOLD_CYCLES = 400;
  localparam int          MAX_REPORTS      = 40;
  localparam int unsigned CYCLE_LIMIT      = 1000000;
  localparam logic        REQ_DRAIN        = ~REQ_PUSH;

  typedef struct packed {
    logic               req_type;
    logic [DEPTH_W-1:0] depth;
  } pixel_req_t;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic               out_valid;
    logic               row_last;
  } pixel_result_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } reg_write_t;

  logic clk;
  logic rst;

  drsm_req_if req_ch ();
  drsm_rsp_if rsp_ch ();
  drsm_cfg_if cfg_ch ();

  depth_row_edge_preserving_smoother_core #(
    .MAX_ROW_PIXELS (ROW_PIXELS)
  ) u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Stimulus side
  pixel_req_t    pixel_reqs_q[$];
  reg_write_t    cfg_writes_q[$];
  int            send_gap_pct;
  int            recv_stall_pct;
  bit            hold_request;
  bit            hold_taken;
  int            hold_left;
  int unsigned   cycle_count = 0;
  int            mismatches  = 0;

  // Predictor state: own copy of the core's registers and row store
  pixel_result_t       smoothed_q[$];
  logic [DEPTH_W-1:0]  row_mem [0:2*ROW_PIXELS-1];
  logic [DEPTH_W-1:0]  blend_acc;
  logic [DEPTH_W-1:0]  prev_raw;
  int unsigned         wr_col;
  int unsigned         rd_col;
  bit                  bank;
  bit                  row_pending;
  logic [WEIGHT_W-1:0] cfg_weight;
  logic [LIMIT_W-1:0]  cfg_limit;
  logic [ROWW_W-1:0]   cfg_width;

  // Row width in use: saturated to [1, ROW_PIXELS]
  function automatic int unsigned clamp_width(input logic [ROWW_W-1:0] w);
    if (w == '0) return 1;
    if (w > ROW_PIXELS) return ROW_PIXELS;
    return w;
  endfunction

  function automatic bit close_enough(input logic [DEPTH_W-1:0] a, input logic [DEPTH_W-1:0] b);
    logic [DEPTH_W-1:0] diff;
    diff = (a > b) ? a - b : b - a;
    return diff < cfg_limit;
  endfunction

  // Q8 blend, round half up; weights above one are taken as one
  function automatic logic [DEPTH_W-1:0] blend(input logic [DEPTH_W-1:0] x,
                                               input logic [DEPTH_W-1:0] st);
    int unsigned w;
    int unsigned acc;
    w   = (cfg_weight > BLEND_ONE) ? int'(BLEND_ONE) : cfg_weight;
    acc = x * w + st * (int'(BLEND_ONE) - w) + ROUND_HALF;
    return DEPTH_W'(acc >> 8);
  endfunction

  // Right-to-left pass over the left-to-right result of a finished row.
  // The edge test looks at the pass input, not at what was already rewritten.
  task automatic sweep_right_to_left(input int unsigned base, input int unsigned len);
    logic [DEPTH_W-1:0] st;
    logic [DEPTH_W-1:0] prev;
    logic [DEPTH_W-1:0] z;
    int unsigned        i;
    st   = row_mem[base + len - 1];
    prev = st;
    i    = len - 1;
    while (i > 0) begin
      i--;
      z = row_mem[base + i];
      if (z != '0) begin
        if (prev != '0 && close_enough(prev, z)) begin
          st = blend(z, st);
          row_mem[base + i] = st;
        end else begin
          st = z;
        end
      end
      prev = z;
    end
  endtask

  // One accepted request: readout of the pending row first, then the push.
  // A row finished by this push only shows from the next request on.
  task automatic smoother_step(input logic rq, input logic [DEPTH_W-1:0] px);
    pixel_result_t      res;
    int unsigned        width;
    int unsigned        col;
    int unsigned        base;
    logic [DEPTH_W-1:0] y;
    width = clamp_width(cfg_width);
    res   = '0;
    if (row_pending) begin
      col           = (rd_col < ROW_PIXELS) ? rd_col : ROW_PIXELS - 1;
      base          = bank ? 0 : ROW_PIXELS;
      res.depth     = row_mem[base + col];
      res.out_valid = 1'b1;
      res.row_last  = (rd_col + 1 >= width);
      if (res.row_last) begin
        rd_col      = 0;
        row_pending = 1'b0;
      end else begin
        rd_col++;
      end
    end
    if (rq == REQ_PUSH) begin
      col  = (wr_col < ROW_PIXELS) ? wr_col : ROW_PIXELS - 1;
      base = bank ? ROW_PIXELS : 0;
      if (col == 0) begin
        blend_acc = px;
        y         = px;
      end else if (px != '0) begin
        // blend only across a valid neighbour with no depth edge between
        if (prev_raw != '0 && close_enough(prev_raw, px)) blend_acc = blend(px, blend_acc);
        else blend_acc = px;
        y = blend_acc;
      end else begin
        y = '0;  // holes pass through
      end
      prev_raw           = px;
      row_mem[base + col] = y;
      // a narrowed width ends the row at once, however far the row had got
      if (wr_col + 1 >= width) begin
        sweep_right_to_left(base, col + 1);
        bank        = ~bank;
        wr_col      = 0;
        rd_col      = 0;
        row_pending = 1'b1;
      end else begin
        wr_col++;
      end
    end
    smoothed_q.push_back(res);
  endtask

  function automatic void check_field(input string name, input int unsigned want,
                                      input logic [DEPTH_W-1:0] got);
    if (got !== DEPTH_W'(want)) begin
      if (mismatches < MAX_REPORTS)
        $display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Request driver: a new transfer is offered once the previous one has gone
  always @(posedge clk) begin : drive_reqs
    pixel_req_t next_req;
    if (rst) begin
      req_ch.valid    <= 1'b0;
      req_ch.req_type <= REQ_PUSH;
      req_ch.depth_in <= '0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (pixel_reqs_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        next_req = pixel_reqs_q.pop_front();
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= next_req.req_type;
        req_ch.depth_in <= next_req.depth;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Register write driver
  always @(posedge clk) begin : drive_cfg
    reg_write_t next_write;
    if (rst) begin
      cfg_ch.valid <= 1'b0;
      cfg_ch.index <= REG_BLEND_WEIGHT;
      cfg_ch.data  <= '0;
    end else if (!cfg_ch.valid || cfg_ch.ready) begin
      if (cfg_writes_q.size() != 0) begin
        next_write = cfg_writes_q.pop_front();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= next_write.index;
        cfg_ch.data  <= next_write.data;
      end else begin
        cfg_ch.valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted here so the sender keeps offering meanwhile
  always @(posedge clk) begin
    if (rst) begin
      hold_left  <= 0;
      hold_taken <= 1'b0;
    end else if (hold_request && !hold_taken) begin
      hold_left  <= RECV_HOLD_CYCLES;
      hold_taken <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst) rsp_ch.ready <= 1'b0;
    else rsp_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor: register writes, accepted requests, then result transfers
  always @(posedge clk) begin : monitor
    pixel_result_t want;
    if (rst) begin
      blend_acc   = '0;
      prev_raw    = '0;
      wr_col      = 0;
      rd_col      = 0;
      bank        = 1'b0;
      row_pending = 1'b0;
      cfg_weight  = BLEND_WEIGHT_RST;
      cfg_limit   = EDGE_LIMIT_RST;
      cfg_width   = ROW_WIDTH_RST;
      smoothed_q.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_BLEND_WEIGHT: cfg_weight = cfg_ch.data[WEIGHT_W-1:0];
          REG_EDGE_LIMIT:   cfg_limit  = cfg_ch.data[LIMIT_W-1:0];
          REG_ROW_WIDTH:    cfg_width  = cfg_ch.data[ROWW_W-1:0];
          default: ;
        endcase
      end
      if (req_ch.valid && req_ch.ready) smoother_step(req_ch.req_type, req_ch.depth_in);
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (smoothed_q.size() == 0) begin
          if (mismatches < MAX_REPORTS)
            $display("%0t unexpected result: expected none actual depth %0d valid %0b last %0b",
                     $time, rsp_ch.depth_out, rsp_ch.out_valid, rsp_ch.row_last);
          mismatches++;
        end else begin
          want = smoothed_q.pop_front();
          check_field("depth_out", want.depth, rsp_ch.depth_out);
          check_field("out_valid", want.out_valid, rsp_ch.out_valid);
          check_field("row_last", want.row_last, rsp_ch.row_last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic queue_request(input logic rq, input logic [DEPTH_W-1:0] px);
    pixel_reqs_q.push_back('{req_type: rq, depth: px});
  endtask

  // Nothing queued, nothing in flight, no result outstanding
  task automatic wait_drained();
    while (pixel_reqs_q.size() != 0 || req_ch.valid || smoothed_q.size() != 0 ||
           cfg_writes_q.size() != 0 || cfg_ch.valid)
      @(negedge clk);
  endtask

  // Mostly smooth row runs with holes and the odd depth edge, around the edge
  // limit in use; short bursts of raw noise and stray drains in between.
  task automatic queue_depth_rows(input int n, input int drain_pct);
    int                 count;
    int                 run_len;
    int                 span;
    int                 v;
    int                 roll;
    logic [DEPTH_W-1:0] level;
    count = 0;
    span  = (cfg_limit == '0) ? 64 : (cfg_limit > 1500) ? 3000 : 2 * int'(cfg_limit);
    while (count < n) begin
      if ($urandom_range(99) < 15) begin
        run_len = $urandom_range(1, 4);
        repeat (run_len) begin
          case ($urandom_range(3))
            0:       v = 0;
            1:       v = 65535;
            default: v = $urandom_range(65535);
          endcase
          queue_request(1'($urandom_range(1)), DEPTH_W'(v));
        end
        count += run_len;
      end else begin
        run_len = $urandom_range(2, 40);
        level   = DEPTH_W'($urandom_range(1, 65535));
        repeat (run_len) begin
          if ($urandom_range(99) < drain_pct) begin
            queue_request(REQ_DRAIN, '0);
            count++;
          end
          roll = $urandom_range(99);
          if (roll < 8) begin
            v = 0;
          end else if (roll < 13) begin
            v     = $urandom_range(1, 65535);
            level = DEPTH_W'(v);
          end else begin
            v = int'(level) + int'($urandom_range(2 * span)) - span;
            if (v < 1) v = 1;
            if (v > 65535) v = 65535;
            level = DEPTH_W'(v);
          end
          queue_request(REQ_PUSH, DEPTH_W'(v));
        end
        count += run_len;
      end
    end
  endtask

  // New register settings, only with the core idle and any row sweep done.
  // A widening width first has the pending row read out in full, so the
  // readout never walks into columns that were never written.
  task automatic run_phase(input logic [WEIGHT_W-1:0] weight, input logic [LIMIT_W-1:0] lim,
                           input logic [ROWW_W-1:0] width, input int n, input int drain_pct);
    int unsigned remaining;
    wait_drained();
    repeat (SWEEP_SETTLE) @(negedge clk);
    if (row_pending && clamp_width(width) > clamp_width(cfg_width)) begin
      remaining = clamp_width(cfg_width) - rd_col;
      repeat (remaining) queue_request(REQ_DRAIN, '0);
      wait_drained();
    end
    cfg_writes_q.push_back('{index: REG_BLEND_WEIGHT, data: CFG_DATA_W'(weight)});
    cfg_writes_q.push_back('{index: REG_EDGE_LIMIT,   data: CFG_DATA_W'(lim)});
    cfg_writes_q.push_back('{index: REG_ROW_WIDTH,    data: CFG_DATA_W'(width)});
    wait_drained();
    queue_depth_rows(n, drain_pct);
  endtask

  initial begin : stimulus
    rst             = 1'b1;
    req_ch.valid    = 1'b0;
    req_ch.req_type = REQ_PUSH;
    req_ch.depth_in = '0;
    rsp_ch.ready    = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = REG_BLEND_WEIGHT;
    cfg_ch.data     = '0;
    hold_request    = 1'b0;
    send_gap_pct    = 18;
    recv_stall_pct  = 66;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: four-pixel rows
    run_phase(9'd128, 16'd20, 11'd4, 0, 0);
    queue_request(REQ_DRAIN, '0);            // nothing ready yet
    queue_request(REQ_PUSH, 16'd1000);       // blend, blend, then an edge
    queue_request(REQ_PUSH, 16'd1010);
    queue_request(REQ_PUSH, 16'd1005);
    queue_request(REQ_PUSH, 16'd1030);
    queue_request(REQ_PUSH, 16'd65535);      // top of range, hole mid-row;
    queue_request(REQ_PUSH, 16'd65530);      // readout of the first row meanwhile
    queue_request(REQ_PUSH, 16'd0);
    queue_request(REQ_PUSH, 16'd65520);
    queue_request(REQ_DRAIN, '0);
    queue_request(REQ_PUSH, 16'd0);          // row of holes bar the last pixel
    queue_request(REQ_PUSH, 16'd0);
    queue_request(REQ_PUSH, 16'd0);
    queue_request(REQ_PUSH, 16'd1);
    repeat (5) queue_request(REQ_DRAIN, '0); // reads past the row end too

    // Sender idles lightly, receiver heavily
    run_phase(9'd64, 16'd1, 11'd2, 40, 20);
    run_phase(9'd256, 16'd65535, 11'd8, 40, 20);      // no smoothing, edges never stop it
    run_phase(9'd511, 16'd0, 11'd1, 30, 20);          // weight saturates, blending off

    // The other way round
    wait_drained();
    send_gap_pct   = 66;
    recv_stall_pct = 18;
    run_phase(9'd200, 16'd300, 11'd0, 20, 20);        // width of zero taken as one
    run_phase(9'd100, 16'd1000, 11'd16, 50, 20);
    hold_request = 1'b1;                              // fills the input queue
    run_phase(9'd64, 16'd500, 11'd5, 50, 25);

    // No idling: a full-width row, then a width past the maximum mid-row,
    // then a narrow width that ends both the row and its readout early
    wait_drained();
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    run_phase(9'd255, 16'd40, ROWW_W'(ROW_PIXELS), 70, 0);
    run_phase(9'd150, 16'd65535, 11'd2047, 20, 0);
    run_phase(9'd128, 16'd20, 11'd3, 30, 20);
    run_phase(9'd128, 16'd20, 11'd7, 30, 20);
    wait_drained();                                   // sender pause until all results are in
    queue_depth_rows(30, 20);
    run_phase(9'd256, 16'd1, 11'd12, 40, 20);

    wait_drained();
    repeat (SWEEP_SETTLE) @(negedge clk);
    if (mismatches == 0 && smoothed_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/drsm_pkg.sv
rtl/drsm_if.sv
rtl/drsm_ram.sv
rtl/drsm_front.sv
rtl/drsm_back.sv
rtl/depth_row_edge_preserving_smoother_core.sv
rtl/drsm_checker.sv
verif/testbench.sv
